// ===== rtl/qrr_pkg.sv =====
// Shared constants for the quadratic real-root pipeline.
// No dependencies; qrr_front, quadratic_real_roots and the checker reference it by scoped name.
package qrr_pkg;

  localparam int FRAC = 8;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_AZERO  = 2'd1;
  localparam logic [1:0] ST_NOREAL = 2'd2;

endpackage

// ===== rtl/qrr_if.sv =====
// Valid/ready channel interfaces for coefficient and root words.
// No dependencies.
interface qrr_in_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] coef_a;
  logic signed [CW-1:0] coef_b;
  logic signed [CW-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrr_out_if #(parameter int RW = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic signed [RW-1:0] root_plus;
  logic signed [RW-1:0] root_minus;
  logic                 saturated;
  modport source (output valid, status, root_plus, root_minus, saturated, input ready);
  modport sink   (input valid, status, root_plus, root_minus, saturated, output ready);
endinterface

// ===== rtl/qrr_front.sv =====
// Discriminant front end: products, then discriminant, status and radicand.
// Depends on qrr_pkg.
module qrr_front #(
  parameter int CW   = 16,
  parameter int RADW = 2*CW + 18
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [CW-1:0] a,
  input  logic signed [CW-1:0] b,
  input  logic signed [CW-1:0] c,
  output logic                 out_v,
  output logic [RADW-1:0]      rad,
  output logic signed [CW-1:0] a_o,
  output logic signed [CW-1:0] b_o,
  output logic [1:0]           status
);

  logic                   v1_r, v2_r;
  logic signed [2*CW-1:0] bb_r, ac_r;
  logic signed [CW-1:0]   a1_r, b1_r, a2_r, b2_r;
  logic [RADW-1:0]        rad_r, rad_nxt;
  logic [1:0]             st_r, st_nxt;
  logic signed [2*CW+2:0] disc;

  always_comb begin
    disc = {{3{bb_r[2*CW-1]}}, bb_r} - {ac_r[2*CW-1], ac_r, 2'b00};
    rad_nxt = '0;
    if (a1_r == '0) begin
      st_nxt = qrr_pkg::ST_AZERO;
    end else if (disc[2*CW+2]) begin
      st_nxt = qrr_pkg::ST_NOREAL;
    end else begin
      st_nxt = qrr_pkg::ST_OK;
      rad_nxt = {{(RADW-2*CW-1-2*qrr_pkg::FRAC){1'b0}}, disc[2*CW:0],
                 {(2*qrr_pkg::FRAC){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bb_r  <= b * b;
      ac_r  <= a * c;
      a1_r  <= a;
      b1_r  <= b;
      rad_r <= rad_nxt;
      st_r  <= st_nxt;
      a2_r  <= a1_r;
      b2_r  <= b1_r;
    end
  end

  assign out_v  = v2_r;
  assign rad    = rad_r;
  assign a_o    = a2_r;
  assign b_o    = b2_r;
  assign status = st_r;

endmodule

// ===== rtl/qrr_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side tag.
// No dependencies.
module qrr_sqrt #(
  parameter int RADW = 50,
  parameter int TW   = 34
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [RADW-1:0]   rad,
  input  logic [TW-1:0]     tag_i,
  output logic              out_v,
  output logic [RADW/2-1:0] root,
  output logic [TW-1:0]     tag_o
);

  localparam int SW = RADW / 2;

  logic            v_w    [SW+1];
  logic [RADW-1:0] rad_w  [SW+1];
  logic [SW+1:0]   rem_w  [SW+1];
  logic [SW-1:0]   root_w [SW+1];
  logic [TW-1:0]   tag_w  [SW+1];

  assign v_w[0]    = in_v;
  assign rad_w[0]  = rad;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign tag_w[0]  = tag_i;

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic            v_r;
    logic [RADW-1:0] rad_r;
    logic [SW+1:0]   rem_r;
    logic [SW-1:0]   root_r;
    logic [TW-1:0]   tag_r;
    logic [SW+3:0]   nr, tr, diff;
    logic            ge;

    always_comb begin
      nr   = {rem_w[i], rad_w[i][RADW-1 -: 2]};
      tr   = {2'b00, root_w[i], 2'b01};
      diff = nr - tr;
      ge   = (nr >= tr);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r  <= rad_w[i] << 2;
        rem_r  <= ge ? diff[SW+1:0] : nr[SW+1:0];
        root_r <= {root_w[i][SW-2:0], ge};
        tag_r  <= tag_w[i];
      end
    end

    assign v_w[i+1]    = v_r;
    assign rad_w[i+1]  = rad_r;
    assign rem_w[i+1]  = rem_r;
    assign root_w[i+1] = root_r;
    assign tag_w[i+1]  = tag_r;
  end

  assign out_v = v_w[SW];
  assign root  = root_w[SW];
  assign tag_o = tag_w[SW];

endmodule

// ===== rtl/qrr_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// No dependencies.
module qrr_div #(
  parameter int QW = 33,
  parameter int DW = 16,
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [QW-1:0] dvd,
  input  logic [DW-1:0] dvs,
  input  logic          neg_i,
  input  logic [TW-1:0] tag_i,
  output logic          out_v,
  output logic [QW-1:0] quo,
  output logic          neg_o,
  output logic [TW-1:0] tag_o
);

  logic          v_w   [QW+1];
  logic [QW-1:0] qd_w  [QW+1];
  logic [DW-1:0] rem_w [QW+1];
  logic [DW-1:0] dvs_w [QW+1];
  logic          neg_w [QW+1];
  logic [TW-1:0] tag_w [QW+1];

  assign v_w[0]   = in_v;
  assign qd_w[0]  = dvd;
  assign rem_w[0] = '0;
  assign dvs_w[0] = dvs;
  assign neg_w[0] = neg_i;
  assign tag_w[0] = tag_i;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          v_r;
    logic [QW-1:0] qd_r;
    logic [DW-1:0] rem_r;
    logic [DW-1:0] dvs_r;
    logic          neg_r;
    logic [TW-1:0] tag_r;
    logic [DW:0]   t, diff;
    logic          ge;

    always_comb begin
      t    = {rem_w[i], qd_w[i][QW-1]};
      diff = t - {1'b0, dvs_w[i]};
      ge   = (t >= {1'b0, dvs_w[i]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qd_r  <= {qd_w[i][QW-2:0], ge};
        rem_r <= ge ? diff[DW-1:0] : t[DW-1:0];
        dvs_r <= dvs_w[i];
        neg_r <= neg_w[i];
        tag_r <= tag_w[i];
      end
    end

    assign v_w[i+1]   = v_r;
    assign qd_w[i+1]  = qd_r;
    assign rem_w[i+1] = rem_r;
    assign dvs_w[i+1] = dvs_r;
    assign neg_w[i+1] = neg_r;
    assign tag_w[i+1] = tag_r;
  end

  assign out_v = v_w[QW];
  assign quo   = qd_w[QW];
  assign neg_o = neg_w[QW];
  assign tag_o = tag_w[QW];

endmodule

// ===== rtl/quadratic_real_roots.sv =====
// Words pass the front end, the bit-per-stage square root, a numerator register, the two
// bit-per-stage dividers, a clip register and a two-entry output (register plus skid).
// Throughput: one word per cycle while the skid entry is empty; the output absorbs stalls.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
// Depends on qrr_pkg, qrr_if, qrr_front, qrr_sqrt and qrr_div.
module quadratic_real_roots #(
  parameter int COEF_WIDTH = 16,
  parameter int ROOT_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  qrr_in_if.sink          in_word,
  qrr_out_if.source       out_word
);

  localparam int CW   = COEF_WIDTH;
  localparam int RW   = ROOT_WIDTH;
  localparam int RADW = 2*CW + 18;
  localparam int SW   = RADW / 2;
  localparam int NW   = CW + 11;
  localparam int QW   = NW - 1 + qrr_pkg::FRAC - 1;
  localparam int MW   = ((QW + 1 > RW) ? QW + 1 : RW) + 1;
  localparam int TW   = 2 + 2*CW;
  localparam logic [MW-1:0] HI = {{(MW-RW+1){1'b0}}, {(RW-1){1'b1}}};
  localparam logic [MW-1:0] LO = ~HI;

  logic en;

  logic                 f_v;
  logic [RADW-1:0]      f_rad;
  logic signed [CW-1:0] f_a, f_b;
  logic [1:0]           f_st;

  logic          s_v;
  logic [SW-1:0] s_root;
  logic [TW-1:0] s_tag;

  logic                 n_v_r;
  logic [QW-1:0]        dvd_p_r, dvd_m_r;
  logic [CW-1:0]        am_r;
  logic                 neg_p_r, neg_m_r;
  logic [1:0]           n_st_r;
  logic signed [CW-1:0] s_a, s_b;
  logic signed [NW-1:0] nb, np, nm;
  logic [NW-1:0]        mp, mm;
  logic [CW-1:0]        am_nxt;

  logic          dp_v, dm_v, dp_neg, dm_neg;
  logic [QW-1:0] dp_q, dm_q;
  logic [1:0]    d_st, dm_st;

  logic                 fin_v_r;
  logic [1:0]           fin_st_r;
  logic signed [RW-1:0] fin_p_r, fin_m_r, fin_p_nxt, fin_m_nxt;
  logic                 fin_sat_r, fin_sat_nxt, sat_p, sat_m;

  logic                 out_v_r, skid_v_r;
  logic [1:0]           out_st_r, skid_st_r;
  logic signed [RW-1:0] out_p_r, out_m_r, skid_p_r, skid_m_r;
  logic                 out_sat_r, skid_sat_r;

  assign en            = !skid_v_r;
  assign in_word.ready = en;

  qrr_front #(.CW(CW), .RADW(RADW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (in_word.valid),
    .a      (in_word.coef_a),
    .b      (in_word.coef_b),
    .c      (in_word.coef_c),
    .out_v  (f_v),
    .rad    (f_rad),
    .a_o    (f_a),
    .b_o    (f_b),
    .status (f_st)
  );

  qrr_sqrt #(.RADW(RADW), .TW(TW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (f_v),
    .rad   (f_rad),
    .tag_i ({f_st, f_a, f_b}),
    .out_v (s_v),
    .root  (s_root),
    .tag_o (s_tag)
  );

  always_comb begin
    s_a    = s_tag[2*CW-1:CW];
    s_b    = s_tag[CW-1:0];
    nb     = -$signed({{3{s_b[CW-1]}}, s_b, {qrr_pkg::FRAC{1'b0}}});
    np     = nb + $signed({2'b00, s_root});
    nm     = nb - $signed({2'b00, s_root});
    mp     = np[NW-1] ? -np : np;
    mm     = nm[NW-1] ? -nm : nm;
    am_nxt = s_a[CW-1] ? -s_a : s_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
    end else if (en) begin
      n_v_r <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_p_r <= {mp[NW-2:0], {(qrr_pkg::FRAC-1){1'b0}}};
      dvd_m_r <= {mm[NW-2:0], {(qrr_pkg::FRAC-1){1'b0}}};
      am_r    <= am_nxt;
      neg_p_r <= np[NW-1] ^ s_a[CW-1];
      neg_m_r <= nm[NW-1] ^ s_a[CW-1];
      n_st_r  <= s_tag[TW-1 -: 2];
    end
  end

  qrr_div #(.QW(QW), .DW(CW), .TW(2)) u_div_p (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (n_v_r),
    .dvd   (dvd_p_r),
    .dvs   (am_r),
    .neg_i (neg_p_r),
    .tag_i (n_st_r),
    .out_v (dp_v),
    .quo   (dp_q),
    .neg_o (dp_neg),
    .tag_o (d_st)
  );

  qrr_div #(.QW(QW), .DW(CW), .TW(2)) u_div_m (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (n_v_r),
    .dvd   (dvd_m_r),
    .dvs   (am_r),
    .neg_i (neg_m_r),
    .tag_i (n_st_r),
    .out_v (dm_v),
    .quo   (dm_q),
    .neg_o (dm_neg),
    .tag_o (dm_st)
  );

  function automatic logic [RW:0] clip(input logic [QW-1:0] mag, input logic neg);
    logic [QW:0]   q;
    logic [MW-1:0] x;
    q = neg ? -{1'b0, mag} : {1'b0, mag};
    x = {{(MW-QW-1){q[QW]}}, q};
    if ($signed(x) > $signed(HI)) begin
      clip = {1'b1, HI[RW-1:0]};
    end else if ($signed(x) < $signed(LO)) begin
      clip = {1'b1, LO[RW-1:0]};
    end else begin
      clip = {1'b0, x[RW-1:0]};
    end
  endfunction

  always_comb begin
    {sat_p, fin_p_nxt} = clip(dp_q, dp_neg);
    {sat_m, fin_m_nxt} = clip(dm_q, dm_neg);
    fin_sat_nxt = sat_p | sat_m;
    if (d_st != qrr_pkg::ST_OK) begin
      fin_p_nxt   = '0;
      fin_m_nxt   = '0;
      fin_sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= dp_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_st_r  <= d_st;
      fin_p_r   <= fin_p_nxt;
      fin_m_r   <= fin_m_nxt;
      fin_sat_r <= fin_sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_word.ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (fin_v_r) begin
      if (!out_v_r || out_word.ready) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_word.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_word.ready) begin
        out_st_r  <= skid_st_r;
        out_p_r   <= skid_p_r;
        out_m_r   <= skid_m_r;
        out_sat_r <= skid_sat_r;
      end
    end else if (fin_v_r) begin
      if (!out_v_r || out_word.ready) begin
        out_st_r  <= fin_st_r;
        out_p_r   <= fin_p_r;
        out_m_r   <= fin_m_r;
        out_sat_r <= fin_sat_r;
      end else begin
        skid_st_r  <= fin_st_r;
        skid_p_r   <= fin_p_r;
        skid_m_r   <= fin_m_r;
        skid_sat_r <= fin_sat_r;
      end
    end
  end

  assign out_word.valid      = out_v_r;
  assign out_word.status     = out_st_r;
  assign out_word.root_plus  = out_p_r;
  assign out_word.root_minus = out_m_r;
  assign out_word.saturated  = out_sat_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without an output word");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_v == dm_v) && (!dp_v || d_st == dm_st))
    else $error("divider lanes out of step");

  a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_st_r != qrr_pkg::ST_OK) |->
      (out_p_r == '0 && out_m_r == '0 && !out_sat_r))
    else $error("nonzero roots on a special-case word");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_v_r && !skid_v_r))
    else $error("output not empty after reset");

endmodule

// ===== tb/quadratic_real_roots_chk.sv =====
// Watches the coefficient and root channels and checks each root word.
// Depends on qrr_pkg and qrr_if; predicts roots with 64-bit arithmetic.
module quadratic_real_roots_chk (
  input  logic       clk,
  input  logic       rst_n,
  qrr_in_if          in_word,
  qrr_out_if         out_word,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]   status;
    logic [31:0]  root_plus;
    logic [31:0]  root_minus;
    logic         saturated;
  } roots_t;

  roots_t roots_q[$];

  function automatic longint isqrt64(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip32(longint q, inout logic sat);
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (q < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return q;
  endfunction

  function automatic roots_t solve_roots(logic signed [15:0] ca, logic signed [15:0] cb,
                                         logic signed [15:0] cc);
    roots_t r;
    longint a, b, c, disc, s, qp, qm;
    logic sat;
    r = '0;
    sat = 1'b0;
    a = ca;
    b = cb;
    c = cc;
    if (a == 0) begin
      r.status = qrr_pkg::ST_AZERO;
      return r;
    end
    disc = b * b - 4 * a * c;
    if (disc < 0) begin
      r.status = qrr_pkg::ST_NOREAL;
      return r;
    end
    s = isqrt64(longint'(disc) << 16);
    qp = clip32(((-b * 256 + s) * 128) / a, sat);
    qm = clip32(((-b * 256 - s) * 128) / a, sat);
    r.status = qrr_pkg::ST_OK;
    r.root_plus = qp[31:0];
    r.root_minus = qm[31:0];
    r.saturated = sat;
    return r;
  endfunction

  assign pending = roots_q.size();

  always @(posedge clk) begin
    roots_t exp_r;
    int     nerr;
    nerr = 0;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (in_word.valid && in_word.ready)
        roots_q.push_back(solve_roots(in_word.coef_a, in_word.coef_b, in_word.coef_c));
      if (out_word.valid && out_word.ready) begin
        if (roots_q.size() == 0) begin
          $error("unexpected root word");
          nerr++;
        end else begin
          exp_r = roots_q.pop_front();
          if (out_word.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, out_word.status);
            nerr++;
          end
          if (out_word.root_plus !== exp_r.root_plus) begin
            $error("root_plus exp %0d got %0d", $signed(exp_r.root_plus),
                   out_word.root_plus);
            nerr++;
          end
          if (out_word.root_minus !== exp_r.root_minus) begin
            $error("root_minus exp %0d got %0d", $signed(exp_r.root_minus),
                   out_word.root_minus);
            nerr++;
          end
          if (out_word.saturated !== exp_r.saturated) begin
            $error("saturated exp %0d got %0d", exp_r.saturated, out_word.saturated);
            nerr++;
          end
        end
      end
      errors <= errors + nerr;
    end
  end
endmodule

// ===== tb/quadratic_real_roots_tb.sv =====
// Drives coefficient words into quadratic_real_roots with random gaps and stalls.
// Depends on qrr_if, the block and quadratic_real_roots_chk.
module quadratic_real_roots_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   hold_off;
  logic sent_all;
  logic [15:0] dir_a[$];
  logic [15:0] dir_b[$];
  logic [15:0] dir_c[$];

  qrr_in_if  #(.CW(16)) in_word();
  qrr_out_if #(.RW(32)) out_word();

  quadratic_real_roots dut (.clk(clk), .rst_n(rst_n), .in_word(in_word), .out_word(out_word));

  quadratic_real_roots_chk chk (.clk(clk), .rst_n(rst_n), .in_word(in_word),
                                .out_word(out_word), .errors(errors), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic add_dir(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    dir_a.push_back(a);
    dir_b.push_back(b);
    dir_c.push_back(c);
  endtask

  task automatic send_word(logic [15:0] a, logic [15:0] b, logic [15:0] c, int gap);
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid  <= 1'b1;
    in_word.coef_a <= a;
    in_word.coef_b <= b;
    in_word.coef_c <= c;
    do @(posedge clk); while (!in_word.ready);
  endtask

  // a mix of zero, small, extreme and full-range coefficients
  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'($signed($urandom_range(0, 4096)) - 2048);
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      3: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] a, b, c;
    rst_n = 1'b0;
    in_word.valid = 1'b0;
    in_word.coef_a = '0;
    in_word.coef_b = '0;
    in_word.coef_c = '0;
    sent_all = 1'b0;
    add_dir(16'h0000, 16'h0100, 16'h0100);
    add_dir(16'h0100, 16'h0000, 16'h0100);
    add_dir(16'h0100, 16'hfd00, 16'h0200);
    add_dir(16'h0100, 16'h0200, 16'h0100);
    add_dir(16'h7fff, 16'h7fff, 16'h7fff);
    add_dir(16'h8000, 16'h8000, 16'h8000);
    add_dir(16'h8000, 16'h7fff, 16'h7fff);
    add_dir(16'h7fff, 16'h8000, 16'h8000);
    add_dir(16'h0001, 16'h7fff, 16'h0000);
    add_dir(16'h0001, 16'h8000, 16'h8000);
    add_dir(16'hffff, 16'h7fff, 16'h7fff);
    add_dir(16'hffff, 16'h0000, 16'h7fff);
    add_dir(16'h0001, 16'h0000, 16'h8000);
    add_dir(16'h8000, 16'h0000, 16'h0001);
    add_dir(16'h0000, 16'h0000, 16'h0000);
    add_dir(16'hff00, 16'h0000, 16'h0400);
    add_dir(16'h0100, 16'h0000, 16'h0000);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_a[i]) send_word(dir_a[i], dir_b[i], dir_c[i], $urandom_range(0, 3));
    in_word.valid <= 1'b0;
    // drain before the random part
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1950; n++) begin
      a = pick_coef();
      b = pick_coef();
      c = pick_coef();
      send_word(a, b, c, (n % 400 < 100) ? 0 : $urandom_range(0, 15));
    end
    in_word.valid <= 1'b0;
    sent_all <= 1'b1;
  end

  initial begin
    out_word.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        out_word.ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      out_word.ready <= 1'b1;
      do @(posedge clk); while (!out_word.valid);
      if ($urandom_range(0, 3) == 0) begin
        out_word.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  initial begin
    hold_off = 0;
    wait (rst_n);
    repeat (200) @(posedge clk);
    hold_off = 300;
  end

  initial begin
    wait (sent_all);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/qrr_pkg.sv
rtl/qrr_if.sv
rtl/qrr_front.sv
rtl/qrr_sqrt.sv
rtl/qrr_div.sv
rtl/quadratic_real_roots.sv
tb/quadratic_real_roots_chk.sv
tb/quadratic_real_roots_tb.sv
